/* rtl/hpf_pkg.sv */
package hpf_pkg;

   // Histogram geometry
   localparam int MAX_BINS   = 4096;
   localparam int COUNT_BITS = 24;
   localparam int IDX_W      = $clog2(MAX_BINS);
   localparam int LOAD_W     = IDX_W + 1;
   localparam int TOTAL_W    = COUNT_BITS + IDX_W;

   // Percentile in hundredths of a percent
   localparam int PCT_W = 14;
   localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(10000);
   localparam logic [PCT_W-1:0] PCT_RESET  = PCT_W'(5000);
   // Round-half-up folded into the scan compare: prefix*10000 + 4999 >= pct*total
   localparam logic [PCT_W-1:0] HALF_ROUND = PCT_W'(10000 / 2 - 1);

   // Target product pct * total, built from two half-width products
   localparam int HALF_W      = (TOTAL_W + 1) / 2;
   localparam int HALF_PROD_W = PCT_W + HALF_W;
   localparam int PROD_W      = PCT_W + TOTAL_W;
   localparam int MUL_W       = COUNT_BITS + PCT_W;

   // Stream payload widths
   localparam int REQ_TDATA_W = ((COUNT_BITS + 7) / 8) * 8;
   localparam int BIN_OUT_W   = 12;
   localparam int RSP_TDATA_W = ((BIN_OUT_W + 7) / 8) * 8;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_PCT_IDX = 1'b0;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_MUL,
      ST_TARGET,
      ST_SCAN
   } ctrl_state_type;

   typedef struct packed {
      logic load;     // item accepted this cycle
      logic mul;      // capture partial products
      logic target;   // form target, arm scan
      logic scan;     // scan pipeline running
      logic finish;   // capture result, clear histogram
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_stat_type;

endpackage

/* rtl/hpf_datapath.sv */
module hpf_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  hpf_pkg::ctrl_cmd_type              cmd,
   input  logic [hpf_pkg::COUNT_BITS-1:0]     bin_count,
   input  logic [hpf_pkg::PCT_W-1:0]          pct,
   output hpf_pkg::dp_stat_type               stat,
   output logic [hpf_pkg::BIN_OUT_W-1:0]      out_bin,
   output logic                               out_overflow
);

   // bin storage
   logic [hpf_pkg::COUNT_BITS-1:0] mem [hpf_pkg::MAX_BINS];

   logic [hpf_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [hpf_pkg::LOAD_W-1:0]  loaded_ff, loaded_in;
   logic                        overflow_ff, overflow_in;
   logic                        full;
   logic                        wr_en;

   logic [hpf_pkg::PCT_W-1:0]       pct_sat;
   logic [hpf_pkg::HALF_W-1:0]      total_lo, total_hi;
   logic [hpf_pkg::HALF_PROD_W-1:0] prod_lo_ff, prod_hi_ff;
   logic [hpf_pkg::PROD_W-1:0]      target_ff;

   logic [hpf_pkg::IDX_W-1:0]      scan_idx_ff;
   logic                           issued_all_ff;
   logic                           issue;
   logic [hpf_pkg::IDX_W-1:0]      last_idx;
   logic [hpf_pkg::COUNT_BITS-1:0] rd_data_ff;
   logic                           s1_valid_ff;
   logic [hpf_pkg::IDX_W-1:0]      s1_idx_ff;
   logic [hpf_pkg::MUL_W-1:0]      mul_ff;
   logic                           s2_valid_ff;
   logic [hpf_pkg::IDX_W-1:0]      s2_idx_ff;
   logic [hpf_pkg::PROD_W-1:0]     acc_ff, acc_sum;
   logic                           hit, exhausted;
   logic [hpf_pkg::BIN_OUT_W-1:0]  out_bin_ff;
   logic                           out_overflow_ff;

   // ---- load side ----
   assign full  = (loaded_ff == hpf_pkg::LOAD_W'(hpf_pkg::MAX_BINS));
   assign wr_en = cmd.load && !full;

   always_comb begin
      total_in    = total_ff;
      loaded_in   = loaded_ff;
      overflow_in = overflow_ff;
      if (cmd.finish) begin
         total_in    = '0;
         loaded_in   = '0;
         overflow_in = 1'b0;
      end else if (wr_en) begin
         total_in  = total_ff + hpf_pkg::TOTAL_W'(bin_count);
         loaded_in = loaded_ff + hpf_pkg::LOAD_W'(1);
      end else if (cmd.load) begin
         overflow_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         loaded_ff   <= '0;
         overflow_ff <= 1'b0;
      end else begin
         total_ff    <= total_in;
         loaded_ff   <= loaded_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[loaded_ff[hpf_pkg::IDX_W-1:0]] <= bin_count;
      end
      rd_data_ff <= mem[scan_idx_ff];
   end

   // ---- target = pct * total, in two halves ----
   assign pct_sat  = (pct > hpf_pkg::PCT_FULL) ? hpf_pkg::PCT_FULL : pct;
   assign total_lo = total_ff[hpf_pkg::HALF_W-1:0];
   assign total_hi = hpf_pkg::HALF_W'(total_ff[hpf_pkg::TOTAL_W-1:hpf_pkg::HALF_W]);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_lo_ff <= hpf_pkg::HALF_PROD_W'(pct_sat) * hpf_pkg::HALF_PROD_W'(total_lo);
         prod_hi_ff <= hpf_pkg::HALF_PROD_W'(pct_sat) * hpf_pkg::HALF_PROD_W'(total_hi);
      end
      if (cmd.target) begin
         target_ff <= hpf_pkg::PROD_W'(prod_lo_ff)
                    + (hpf_pkg::PROD_W'(prod_hi_ff) << hpf_pkg::HALF_W);
      end
   end

   // ---- scan pipeline: read, scale by 10000, accumulate/compare ----
   assign last_idx  = hpf_pkg::IDX_W'(loaded_ff - hpf_pkg::LOAD_W'(1));
   assign issue     = cmd.scan && !issued_all_ff;
   assign acc_sum   = acc_ff + hpf_pkg::PROD_W'(mul_ff);
   assign hit       = s2_valid_ff && (acc_sum >= target_ff);
   assign exhausted = s2_valid_ff && (s2_idx_ff == last_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff   <= '0;
         issued_all_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         if (cmd.target) begin
            scan_idx_ff   <= '0;
            issued_all_ff <= 1'b0;
         end else if (issue) begin
            scan_idx_ff   <= scan_idx_ff + hpf_pkg::IDX_W'(1);
            issued_all_ff <= (scan_idx_ff == last_idx);
         end
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff && cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= scan_idx_ff;
      s2_idx_ff <= s1_idx_ff;
      mul_ff    <= hpf_pkg::MUL_W'(rd_data_ff) * hpf_pkg::MUL_W'(hpf_pkg::PCT_FULL);
      if (cmd.target) begin
         acc_ff <= hpf_pkg::PROD_W'(hpf_pkg::HALF_ROUND);
      end else if (s2_valid_ff) begin
         acc_ff <= acc_sum;
      end
      if (cmd.finish) begin
         out_bin_ff      <= hit ? hpf_pkg::BIN_OUT_W'(s2_idx_ff) : '0;
         out_overflow_ff <= overflow_ff;
      end
   end

   assign stat.scan_done = hit || exhausted;
   assign out_bin        = out_bin_ff;
   assign out_overflow   = out_overflow_ff;

endmodule

/* rtl/hpf_ctrl.sv */
module hpf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   input  logic                  rsp_tready,
   input  hpf_pkg::dp_stat_type  stat,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   output hpf_pkg::ctrl_cmd_type cmd
);

   hpf_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hpf_pkg::ST_LOAD: begin
            if (req_tvalid && req_tlast) begin
               state_in = hpf_pkg::ST_MUL;
            end
         end
         hpf_pkg::ST_MUL: begin
            state_in = hpf_pkg::ST_TARGET;
         end
         hpf_pkg::ST_TARGET: begin
            // result slot must be empty before the scan may finish
            if (!rsp_valid_ff) begin
               state_in = hpf_pkg::ST_SCAN;
            end
         end
         hpf_pkg::ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = hpf_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = hpf_pkg::ST_LOAD;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         hpf_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         hpf_pkg::ST_MUL: begin
            cmd.mul = 1'b1;
         end
         hpf_pkg::ST_TARGET: begin
            cmd.target = 1'b1;
         end
         hpf_pkg::ST_SCAN: begin
            cmd.scan   = 1'b1;
            cmd.finish = stat.scan_done;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hpf_pkg::ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* rtl/histogram_percentile_finder_core.sv */
// Histogram percentile finder.
// req channel: one histogram bin count per item, in bin order; tlast marks
//   the final bin. Bins past capacity (4096) are dropped and flagged.
// rsp channel: one item per histogram, the first bin index whose running
//   sum reaches round(pct * total / 10000), halves up; tuser flags dropped
//   bins. An empty or all-zero histogram reports bin 0.
// csr port: register 0 (byte address 0) is the percentile in hundredths of
//   a percent, bits [13:0] kept; stored values above 10000 act as 10000. Reset value 5000.
// Timing: bins load at one per cycle. After the last bin the target is formed
//   from two half-width products, then their sum, and the scan walks the
//   stored bins through a 3-stage read/scale/accumulate pipeline, one bin per
//   cycle, stopping at the hit; the result is valid the cycle after the hit.
// req_tready is low from the last bin until the scan ends. A finished result
//   sits in an output register; the next histogram loads while it waits, but
//   its scan holds off until the previous result is taken.
// Reset (synchronous) empties the histogram and the result slot; the bin
//   memory itself is not cleared, only entries written are ever read.
module histogram_percentile_finder_core (
   input  logic                                clock,
   input  logic                                reset,
   // bins in
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hpf_pkg::REQ_TDATA_W-1:0]     req_tdata,   // [23:0] bin_count
   input  logic                                req_tlast,   // last_bin
   // result out
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hpf_pkg::RSP_TDATA_W-1:0]     rsp_tdata,   // [11:0] percentile_bin
   output logic                                rsp_tuser,   // too_many_bins
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hpf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [hpf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [hpf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   hpf_pkg::ctrl_cmd_type        cmd;
   hpf_pkg::dp_stat_type         stat;
   logic [hpf_pkg::PCT_W-1:0]    pct_ff, pct_in;
   logic                         csr_idx;
   logic                         csr_wr;
   logic [hpf_pkg::BIN_OUT_W-1:0] out_bin;
   logic                         out_overflow;

   // register decode: one 32-bit register per word
   assign csr_idx    = csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      pct_in = pct_ff;
      if (csr_wr && (csr_idx == hpf_pkg::CSR_PCT_IDX)) begin
         pct_in = csr_pwdata[hpf_pkg::PCT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pct_ff <= hpf_pkg::PCT_RESET;
      end else begin
         pct_ff <= pct_in;
      end
   end

   assign csr_prdata = (csr_idx == hpf_pkg::CSR_PCT_IDX) ?
                       hpf_pkg::CSR_DATA_W'(pct_ff) : '0;

   hpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   hpf_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .bin_count    (req_tdata[hpf_pkg::COUNT_BITS-1:0]),
      .pct          (pct_ff),
      .stat         (stat),
      .out_bin      (out_bin),
      .out_overflow (out_overflow)
   );

   assign rsp_tdata = hpf_pkg::RSP_TDATA_W'(out_bin);
   assign rsp_tuser = out_overflow;

endmodule
